// ===== rtl/core/mprf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_pkg: shared types and constants
// Widths, the sequencer state type and the control word handed from the
// sequencer to the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mprf_pkg;

   localparam int ModWidth    = 32;
   localparam int MaxFactors  = 16;
   localparam int FacIdxWidth = $clog2(MaxFactors);
   localparam int FacCntWidth = $clog2(MaxFactors + 1);
   localparam int ProdWidth   = 2 * ModWidth;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FAC_TEST,     // issue n mod d
      ST_FAC_TEST_W,
      ST_FAC_STRIP,    // issue n / d
      ST_FAC_STRIP_W,
      ST_FAC_NEXT,
      ST_FAC_SQ,       // d*d vs n
      ST_FAC_END,
      ST_G_START,
      ST_Q_LOAD,       // read factor store
      ST_Q_EXP,        // issue (p-1)/q
      ST_Q_EXP_W,
      ST_PW_STEP,
      ST_PW_MUL_A,     // acc*base mod p
      ST_PW_MUL_A_W,
      ST_PW_MUL_B,     // base*base mod p
      ST_PW_MUL_B_W,
      ST_Q_CHECK,
      ST_DONE
   } state_type;

   // Command to the divider unit
   typedef struct packed {
      logic                 go;
      logic [ProdWidth-1:0] dividend;
      logic [ModWidth-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [ProdWidth-1:0] quot;
      logic [ModWidth-1:0]  rem;
   } div_rsp_type;

endpackage

// ===== rtl/core/mprf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_ram: generic simple dual-port RAM
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mprf_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/mprf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_divider: shared restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit a cycle. Gives both
// quotient and remainder; used for trial division, exponents and mod p.
// ----------------------------------------------------------------------------
module mprf_divider
   import mprf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   localparam int CntWidth = $clog2(ProdWidth + 1);

   logic [ProdWidth-1:0] quot_ff, quot_in;
   logic [ModWidth-1:0]  rem_ff, rem_in;
   logic [ModWidth-1:0]  dvs_ff, dvs_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ModWidth:0]    shifted;

   // load a new command, or take one restoring step
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[ProdWidth-1]};
      if (cmd.go) begin
         quot_in = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = CntWidth'(ProdWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[ProdWidth-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            // difference is below the divisor, so it fits the remainder
            rem_in     = ModWidth'(shifted - {1'b0, dvs_ff});
            quot_in[0] = 1'b1;
         end else begin
            rem_in = shifted[ModWidth-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== rtl/core/min_primitive_root_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_primitive_root_finder: smallest primitive root modulo a prime
// Factors p-1 by trial division, then tests g = 2, 3, ... with
// square-and-multiply powers; all arithmetic runs on one shared divider.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   req_prime_modulus             start & !busy
//  response  rsp_root, rsp_found           rsp_valid, one cycle
//
//  Every modulo, quotient and product reduction goes through the one
//  bit-serial divider. Trial division issues one test per divisor
//  up to sqrt(p), plus one division per strip of a found factor; each
//  candidate then needs up to 1 + 2 * 31 divisions per factor of p-1.
//  Reset clears the sequencer and divider control only; the factor store needs no clearing.
//  busy is high from acceptance until the result strobe; results cannot stall.
// ----------------------------------------------------------------------------
module min_primitive_root_finder
   import mprf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ModWidth-1:0] req_prime_modulus,
   output logic                rsp_valid,
   output logic [ModWidth-1:0] rsp_root,
   output logic                rsp_found
);

   state_type state_ff, state_in;

   logic [ModWidth-1:0]    p_ff, p_in;
   logic [ModWidth-1:0]    n_ff, n_in;       // unfactored part
   logic [ModWidth-1:0]    d_ff, d_in;       // trial divisor
   logic [ModWidth-1:0]    g_ff, g_in;
   logic [ModWidth-1:0]    e_ff, e_in;       // exponent
   logic [ModWidth-1:0]    acc_ff, acc_in;
   logic [ModWidth-1:0]    base_ff, base_in;
   logic [FacCntWidth-1:0] fcnt_ff, fcnt_in;
   logic [FacCntWidth-1:0] k_ff, k_in;
   logic [ModWidth-1:0]    root_ff, root_in;
   logic                   found_ff, found_in;
   logic                   valid_ff, valid_in;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic                   fs_wr;
   logic [FacIdxWidth-1:0] fs_waddr;
   logic [ModWidth-1:0]    fs_wdata;
   logic [ModWidth-1:0]    fs_rdata;
   logic [ProdWidth-1:0]   dd;

   mprf_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   mprf_ram #(.Width(ModWidth), .Depth(MaxFactors)) u_fac_store (
      .clock   (clock),
      .wr_en   (fs_wr),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_addr (k_ff[FacIdxWidth-1:0]),
      .rd_data (fs_rdata)
   );

   assign dd = {{ModWidth{1'b0}}, d_ff} * {{ModWidth{1'b0}}, d_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fcnt_ff  <= fcnt_in;
      end
      p_ff     <= p_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      g_ff     <= g_in;
      e_ff     <= e_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      k_ff     <= k_in;
      root_ff  <= root_in;
      found_ff <= found_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      g_in     = g_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      fcnt_in  = fcnt_ff;
      k_in     = k_ff;
      root_in  = root_ff;
      found_in = found_ff;
      valid_in = 1'b0;
      div_cmd  = '0;
      fs_wr    = 1'b0;
      fs_waddr = fcnt_ff[FacIdxWidth-1:0];
      fs_wdata = d_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               p_in     = req_prime_modulus;
               root_in  = '0;
               found_in = 1'b0;
               fcnt_in  = '0;
               if (req_prime_modulus < ModWidth'(3)) begin
                  state_in = ST_DONE;
               end else begin
                  n_in     = req_prime_modulus - 1'b1;
                  d_in     = ModWidth'(2);
                  state_in = ST_FAC_SQ;
               end
            end
         end
         ST_FAC_SQ: begin
            if (dd <= {{ModWidth{1'b0}}, n_ff}) begin
               state_in = ST_FAC_TEST;
            end else begin
               state_in = ST_FAC_END;
            end
         end
         ST_FAC_TEST: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {{ModWidth{1'b0}}, n_ff};
            div_cmd.divisor  = d_ff;
            state_in         = ST_FAC_TEST_W;
         end
         ST_FAC_TEST_W: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  fs_wr    = (fcnt_ff < FacCntWidth'(MaxFactors));
                  fcnt_in  = fs_wr ? fcnt_ff + 1'b1 : fcnt_ff;
                  state_in = ST_FAC_STRIP;
               end else begin
                  state_in = ST_FAC_NEXT;
               end
            end
         end
         ST_FAC_STRIP: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {{ModWidth{1'b0}}, n_ff};
            div_cmd.divisor  = d_ff;
            state_in         = ST_FAC_STRIP_W;
         end
         ST_FAC_STRIP_W: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  n_in     = div_rsp.quot[ModWidth-1:0];
                  state_in = ST_FAC_STRIP;
               end else begin
                  state_in = ST_FAC_NEXT;
               end
            end
         end
         ST_FAC_NEXT: begin
            d_in     = d_ff + 1'b1;
            state_in = ST_FAC_SQ;
         end
         ST_FAC_END: begin
            // leftover factor above one
            if (n_ff > ModWidth'(1)) begin
               fs_wr    = (fcnt_ff < FacCntWidth'(MaxFactors));
               fs_wdata = n_ff;
               fcnt_in  = fs_wr ? fcnt_ff + 1'b1 : fcnt_ff;
            end
            g_in     = ModWidth'(2);
            state_in = ST_G_START;
         end
         ST_G_START: begin
            k_in = '0;
            if (g_ff >= p_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_Q_LOAD;
            end
         end
         ST_Q_LOAD: begin
            // read data lands next cycle
            if (k_ff >= fcnt_ff) begin
               root_in  = g_ff;
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_Q_EXP;
            end
         end
         ST_Q_EXP: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {{ModWidth{1'b0}}, p_ff - 1'b1};
            div_cmd.divisor  = fs_rdata;
            state_in         = (fs_rdata == '0) ? ST_Q_CHECK : ST_Q_EXP_W;
            acc_in           = ModWidth'(2);   // forces "not one" when q is zero
         end
         ST_Q_EXP_W: begin
            if (div_rsp.done) begin
               e_in     = div_rsp.quot[ModWidth-1:0];
               acc_in   = ModWidth'(1);
               base_in  = g_ff;       // g < p already
               state_in = ST_PW_STEP;
            end
         end
         ST_PW_STEP: begin
            if (e_ff == '0) begin
               state_in = ST_Q_CHECK;
            end else if (e_ff[0]) begin
               state_in = ST_PW_MUL_A;
            end else begin
               state_in = ST_PW_MUL_B;
            end
         end
         ST_PW_MUL_A: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {{ModWidth{1'b0}}, acc_ff} * {{ModWidth{1'b0}}, base_ff};
            div_cmd.divisor  = p_ff;
            state_in         = ST_PW_MUL_A_W;
         end
         ST_PW_MUL_A_W: begin
            if (div_rsp.done) begin
               acc_in   = div_rsp.rem;
               state_in = ST_PW_MUL_B;
            end
         end
         ST_PW_MUL_B: begin
            div_cmd.go       = 1'b1;
            div_cmd.dividend = {{ModWidth{1'b0}}, base_ff} * {{ModWidth{1'b0}}, base_ff};
            div_cmd.divisor  = p_ff;
            state_in         = ST_PW_MUL_B_W;
         end
         ST_PW_MUL_B_W: begin
            if (div_rsp.done) begin
               base_in  = div_rsp.rem;
               e_in     = e_ff >> 1;
               state_in = ST_PW_STEP;
            end
         end
         ST_Q_CHECK: begin
            if (acc_ff == ModWidth'(1)) begin
               g_in     = g_ff + 1'b1;
               state_in = ST_G_START;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_Q_LOAD;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_root  = root_ff;
   assign rsp_found = found_ff;

endmodule

// ===== rtl/core/mprf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprf_checker: port-level checks
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
module mprf_checker
   import mprf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [ModWidth-1:0] req_prime_modulus,
   input logic                rsp_valid,
   input logic [ModWidth-1:0] rsp_root,
   input logic                rsp_found
);

   // accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // result strobe ends the busy period
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // strobe lasts one cycle
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // found and a nonzero root go together
   a_found_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_root != '0)))
      else $error("found flag disagrees with root");

   // only a busy period can end in a result
   a_valid_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work");

endmodule

bind min_primitive_root_finder mprf_checker u_mprf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_prime_modulus (req_prime_modulus),
   .rsp_valid         (rsp_valid),
   .rsp_root          (rsp_root),
   .rsp_found         (rsp_found)
);

// ===== sim/min_primitive_root_finder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_primitive_root_finder_test: self-checking bench for the root finder
// Drives moduli through the start/busy port and scores every result word
// against a behavioural root search or the word typed in its table row. A
// directed table and a walk over powers of two come first, then random primes and noise from a small range.
// ----------------------------------------------------------------------------
module min_primitive_root_finder_test;
   import mprf_pkg::*;

   typedef struct {
      logic [ModWidth-1:0] root;
      logic                found;
   } root_word_type;

   typedef struct {
      logic [ModWidth-1:0] modulus;
      bit                  typed;   // expected word given in the row
      logic [ModWidth-1:0] root;
      logic                found;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ModWidth-1:0] req_prime_modulus;
   logic                rsp_valid;
   logic [ModWidth-1:0] rsp_root;
   logic                rsp_found;

   root_word_type pending_roots[$];
   int            error_count;
   int            words_checked;
   int            items_sent;
   int            primes_sent;
   bit            gap_free;

   min_primitive_root_finder DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_prime_modulus (req_prime_modulus),
      .rsp_valid         (rsp_valid),
      .rsp_root          (rsp_root),
      .rsp_found         (rsp_found)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // g^e mod m, square-and-multiply; operands stay below 2^32
   function automatic longint unsigned power_mod(longint unsigned g, longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      longint unsigned b;
      acc = 1 % m;
      b = g % m;
      while (e != 0) begin
         if (e[0])
            acc = (acc * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return acc;
   endfunction

   // smallest passing candidate for modulus p
   function automatic root_word_type smallest_root(logic [ModWidth-1:0] p_in);
      root_word_type   w;
      longint unsigned p;
      longint unsigned n;
      longint unsigned d;
      longint unsigned g;
      longint unsigned primes[$];
      bit              pass;
      p = p_in;
      w.root = '0;
      w.found = 1'b0;
      if (p < 3)
         return w;
      // distinct prime factors of p-1
      n = p - 1;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) begin
            primes = {primes, d};
            while (n % d == 0)
               n = n / d;
         end
      end
      if (n > 1)
         primes = {primes, n};
      for (g = 2; g < p; g++) begin
         pass = 1'b1;
         foreach (primes[k]) begin
            if (power_mod(g, (p - 1) / primes[k], p) == 1) begin
               pass = 1'b0;
               break;
            end
         end
         if (pass) begin
            w.root = g[ModWidth-1:0];
            w.found = 1'b1;
            return w;
         end
      end
      return w;
   endfunction

   function automatic bit prime_test(int unsigned v);
      int unsigned d;
      if (v < 2)
         return 1'b0;
      for (d = 2; d * d <= v; d++)
         if (v % d == 0)
            return 1'b0;
      return 1'b1;
   endfunction

   // hand one word over; expectation queued at the accepting edge
   task automatic send_modulus(logic [ModWidth-1:0] p, bit typed,
                               root_word_type typed_word);
      int unsigned   gap;
      root_word_type exp_word;
      if (!gap_free && $urandom_range(99) < 22) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_prime_modulus <= p;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      if (typed)
         exp_word = typed_word;
      else
         exp_word = smallest_root(p);
      pending_roots = {pending_roots, exp_word};
      items_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_roots.size() != 0)
         @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      root_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_roots.size() == 0) begin
            $error("unexpected result word: root=%0d found=%0b", rsp_root, rsp_found);
            error_count++;
         end else begin
            want = pending_roots.pop_front();
            words_checked++;
            if (rsp_root !== want.root) begin
               $error("root: expected %0d, got %0d", want.root, rsp_root);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_found);
               error_count++;
            end
         end
      end
   end

   initial begin
      #400ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      stim_row_type  rows[$];
      root_word_type w;
      int unsigned   v;
      int            k;

      reset = 1'b1;
      start = 1'b0;
      req_prime_modulus = '0;
      error_count = 0;
      words_checked = 0;
      items_sent = 0;
      primes_sent = 0;
      gap_free = 1'b0;

      // directed rows: below three, smallest primes, composites, Fermat primes, wide values
      rows = '{
         '{32'd0,          1'b1, 32'd0, 1'b0},
         '{32'd1,          1'b1, 32'd0, 1'b0},
         '{32'd2,          1'b1, 32'd0, 1'b0},
         '{32'd3,          1'b1, 32'd2, 1'b1},
         '{32'd5,          1'b1, 32'd2, 1'b1},
         '{32'd4,          1'b0, 32'd0, 1'b0},
         '{32'd7,          1'b0, 32'd0, 1'b0},
         '{32'd9,          1'b0, 32'd0, 1'b0},
         '{32'd15,         1'b0, 32'd0, 1'b0},
         '{32'd17,         1'b0, 32'd0, 1'b0},
         '{32'd41,         1'b0, 32'd0, 1'b0},
         '{32'd257,        1'b0, 32'd0, 1'b0},
         '{32'd65537,      1'b0, 32'd0, 1'b0},
         '{32'hC000_0001,  1'b0, 32'd0, 1'b0},
         '{32'h8000_0001,  1'b0, 32'd0, 1'b0},
         '{32'd1000000007, 1'b0, 32'd0, 1'b0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         w.root = rows[i].root;
         w.found = rows[i].found;
         send_modulus(rows[i].modulus, rows[i].typed, w);
      end

      // hold off until the block has answered everything
      drain_results();

      // walk a one across the word with even moduli 2^k
      for (k = 2; k <= 30; k++)
         send_modulus(32'd1 << k, 1'b0, w);

      // random part: mostly primes, the rest any small value
      for (int n = 0; n < 55; n++) begin
         gap_free = (n >= 20 && n < 40);
         v = $urandom_range(0, 1500);
         if ($urandom_range(99) < 75) begin
            if (v < 3)
               v = 3;
            while (!prime_test(v))
               v++;
            primes_sent++;
         end
         send_modulus(v, 1'b0, w);
      end

      drain_results();
      repeat (200) @(posedge clock);

      $display("Sent %0d moduli (%0d random primes), checked %0d result words.",
               items_sent, primes_sent, words_checked);
      if (error_count == 0 && pending_roots.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mprf_pkg.sv
rtl/core/mprf_ram.sv
rtl/core/mprf_divider.sv
rtl/core/min_primitive_root_finder.sv
rtl/core/mprf_checker.sv
sim/min_primitive_root_finder_test.sv
